### rtl/core/psg_pkg.sv
// shared types, request codes and the volume table of the sound generator
// no dependencies
package psg_pkg;

  typedef enum logic [2:0] {
    REQ_ADDR   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_READ   = 3'd2,
    REQ_TICK   = 3'd3,
    REQ_SAMPLE = 3'd4
  } req_e;

  localparam logic [3:0] REG_TONE_FINE  = 4'd0;
  localparam logic [3:0] REG_NOISE      = 4'd6;
  localparam logic [3:0] REG_MIXER      = 4'd7;
  localparam logic [3:0] REG_VOL_A      = 4'd8;
  localparam logic [3:0] REG_ENV_FINE   = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE = 4'd12;
  localparam logic [3:0] REG_SHAPE      = 4'd13;
  localparam logic [3:0] REG_PORT_A     = 4'd14;
  localparam logic [3:0] REG_PORT_B     = 4'd15;

  localparam logic signed [17:0] SAT_MAX = 18'sd32767;
  localparam logic signed [17:0] SAT_MIN = -18'sd32768;

  typedef logic [15:0][7:0] reg_file_t;

  // all registers clear except the mixer, which starts with tone and noise disabled on every voice
  localparam reg_file_t REG_FILE_RESET = 128'h0000_0000_0000_0000_ff00_0000_0000_0000;

  typedef struct packed {
    logic [2:0] tone_lvl;
    logic       noise_lvl;
    logic [3:0] env_lvl;
  } gen_status_t;

  function automatic logic [12:0] vol_level(input logic [3:0] idx);
    logic [12:0] v;
    unique case (idx)
      4'd0:    v = 13'd0;
      4'd1:    v = 13'd40;
      4'd2:    v = 13'd59;
      4'd3:    v = 13'd87;
      4'd4:    v = 13'd128;
      4'd5:    v = 13'd184;
      4'd6:    v = 13'd269;
      4'd7:    v = 13'd388;
      4'd8:    v = 13'd555;
      4'd9:    v = 13'd813;
      4'd10:   v = 13'd1152;
      4'd11:   v = 13'd1671;
      4'd12:   v = 13'd2360;
      4'd13:   v = 13'd3406;
      4'd14:   v = 13'd4870;
      default: v = 13'd6982;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/psg_regs.sv
// address latch and 16-byte register file with bus read mux
// depends on psg_pkg
module psg_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  addr_we_i,
  input  logic                  data_we_i,
  input  logic [7:0]            bus_data_i,
  input  logic [7:0]            port_value_i,
  output logic [3:0]            addr_o,
  output logic [7:0]            rd_data_o,
  output psg_pkg::reg_file_t    regs_o
);

  logic [3:0]         addr_q;
  psg_pkg::reg_file_t regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      regs_q <= psg_pkg::REG_FILE_RESET;
    end else begin
      if (addr_we_i) begin
        addr_q <= bus_data_i[3:0];
      end
      if (data_we_i) begin
        regs_q[addr_q] <= bus_data_i;
      end
    end
  end

  // port registers read back the external port byte
  assign rd_data_o = (addr_q == psg_pkg::REG_PORT_A || addr_q == psg_pkg::REG_PORT_B) ?
                     port_value_i : regs_q[addr_q];
  assign addr_o    = addr_q;
  assign regs_o    = regs_q;

endmodule

### rtl/core/psg_gen.sv
// tone, noise and envelope generators advanced by timebase ticks
// depends on psg_pkg
module psg_gen (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_i,
  input  logic                  env_restart_i,
  input  logic                  env_attack_i,
  input  psg_pkg::reg_file_t    regs_i,
  output psg_pkg::gen_status_t  status_o
);

  logic [2:0][11:0] tone_cnt_q, tone_cnt_d;
  logic [2:0]       tone_lvl_q, tone_lvl_d;
  logic [5:0]       noise_cnt_q, noise_cnt_d;
  logic [16:0]      noise_sr_q, noise_sr_d;
  logic             noise_lvl_q, noise_lvl_d;
  logic [15:0]      env_cnt_q, env_cnt_d;
  logic [4:0]       env_pos_q, env_pos_d;
  logic [3:0]       env_lvl_q, env_lvl_d;
  logic             env_stop_q, env_stop_d;

  logic [11:0] tone_per;
  logic [11:0] tone_inc;
  logic [4:0]  noise_sel;
  logic [6:0]  noise_per;
  logic [5:0]  noise_inc;
  logic [15:0] env_per;
  logic [15:0] env_inc;
  logic [4:0]  pos_inc;
  logic        s_cont, s_att, s_alt, s_hold, rising;

  always_comb begin
    tone_cnt_d  = tone_cnt_q;
    tone_lvl_d  = tone_lvl_q;
    noise_cnt_d = noise_cnt_q;
    noise_sr_d  = noise_sr_q;
    noise_lvl_d = noise_lvl_q;
    env_cnt_d   = env_cnt_q;
    env_pos_d   = env_pos_q;
    env_lvl_d   = env_lvl_q;
    env_stop_d  = env_stop_q;
    tone_per    = '0;
    tone_inc    = '0;
    s_cont      = regs_i[psg_pkg::REG_SHAPE][3];
    s_att       = regs_i[psg_pkg::REG_SHAPE][2];
    s_alt       = regs_i[psg_pkg::REG_SHAPE][1];
    s_hold      = regs_i[psg_pkg::REG_SHAPE][0];
    pos_inc     = env_pos_q + 5'd1;
    rising      = s_att ^ (s_cont & s_alt & pos_inc[4]);
    noise_sel   = (regs_i[psg_pkg::REG_NOISE][4:0] == 5'd0) ? 5'd1 :
                  regs_i[psg_pkg::REG_NOISE][4:0];
    noise_per   = {1'b0, noise_sel, 1'b0};
    noise_inc   = noise_cnt_q + 6'd1;
    env_per     = {regs_i[psg_pkg::REG_ENV_COARSE], regs_i[psg_pkg::REG_ENV_FINE]};
    if (env_per == 16'd0) begin
      env_per = 16'd1;
    end
    env_inc     = env_cnt_q + 16'd1;

    if (tick_i) begin
      for (int ch = 0; ch < 3; ch++) begin
        tone_per = {regs_i[psg_pkg::REG_TONE_FINE + 2*ch + 1][3:0],
                    regs_i[psg_pkg::REG_TONE_FINE + 2*ch]};
        if (tone_per == 12'd0) begin
          tone_per = 12'd1;
        end
        tone_inc = tone_cnt_q[ch] + 12'd1;
        if (tone_inc >= tone_per) begin
          tone_cnt_d[ch] = '0;
          tone_lvl_d[ch] = ~tone_lvl_q[ch];
        end else begin
          tone_cnt_d[ch] = tone_inc;
        end
      end

      if ({1'b0, noise_inc} >= noise_per) begin
        noise_cnt_d = '0;
        noise_sr_d  = {noise_sr_q[0] ^ noise_sr_q[3], noise_sr_q[16:1]};
        noise_lvl_d = noise_sr_q[1];
      end else begin
        noise_cnt_d = noise_inc;
      end

      if (env_inc >= env_per) begin
        env_cnt_d = '0;
        if (!env_stop_q) begin
          if ((!s_cont || s_hold) && pos_inc[4]) begin
            env_pos_d  = 5'd15;
            env_stop_d = 1'b1;
            env_lvl_d  = (s_cont && (s_att != s_alt)) ? 4'hf : 4'h0;
          end else begin
            env_pos_d = pos_inc;
            env_lvl_d = rising ? pos_inc[3:0] : ~pos_inc[3:0];
          end
        end
      end else begin
        env_cnt_d = env_inc;
      end
    end

    // shape write restarts the envelope
    if (env_restart_i) begin
      env_cnt_d  = '0;
      env_pos_d  = '0;
      env_stop_d = 1'b0;
      env_lvl_d  = env_attack_i ? 4'h0 : 4'hf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_cnt_q  <= '0;
      tone_lvl_q  <= '0;
      noise_cnt_q <= '0;
      noise_sr_q  <= 17'd1;
      noise_lvl_q <= 1'b0;
      env_cnt_q   <= '0;
      env_pos_q   <= '0;
      env_lvl_q   <= '0;
      env_stop_q  <= 1'b0;
    end else begin
      tone_cnt_q  <= tone_cnt_d;
      tone_lvl_q  <= tone_lvl_d;
      noise_cnt_q <= noise_cnt_d;
      noise_sr_q  <= noise_sr_d;
      noise_lvl_q <= noise_lvl_d;
      env_cnt_q   <= env_cnt_d;
      env_pos_q   <= env_pos_d;
      env_lvl_q   <= env_lvl_d;
      env_stop_q  <= env_stop_d;
    end
  end

  assign status_o.tone_lvl  = tone_lvl_q;
  assign status_o.noise_lvl = noise_lvl_q;
  assign status_o.env_lvl   = env_lvl_q;

endmodule

### rtl/core/psg_mix.sv
// voice mixer: volume lookup, sum with the incoming sample and saturation
// depends on psg_pkg
module psg_mix (
  input  psg_pkg::reg_file_t    regs_i,
  input  psg_pkg::gen_status_t  status_i,
  input  logic signed [15:0]    mix_in_i,
  output logic signed [15:0]    sample_o
);

  logic [14:0]        sum;
  logic [3:0]         idx;
  logic               on;
  logic signed [17:0] total;

  always_comb begin
    sum = '0;
    idx = '0;
    on  = 1'b0;
    for (int ch = 0; ch < 3; ch++) begin
      on  = (regs_i[psg_pkg::REG_MIXER][ch]   | status_i.tone_lvl[ch]) &
            (regs_i[psg_pkg::REG_MIXER][ch+3] | status_i.noise_lvl);
      idx = regs_i[psg_pkg::REG_VOL_A + ch][4] ? status_i.env_lvl :
            regs_i[psg_pkg::REG_VOL_A + ch][3:0];
      if (on) begin
        sum = sum + {2'b00, psg_pkg::vol_level(idx)};
      end
    end
    total = {{2{mix_in_i[15]}}, mix_in_i} + $signed({3'b000, sum});
    if (total > psg_pkg::SAT_MAX) begin
      sample_o = psg_pkg::SAT_MAX[15:0];
    end else if (total < psg_pkg::SAT_MIN) begin
      sample_o = psg_pkg::SAT_MIN[15:0];
    end else begin
      sample_o = total[15:0];
    end
  end

endmodule

### rtl/core/programmable_sound_generator.sv
// top level of the three-voice sound generator: input stage, result stage
// depends on psg_pkg, psg_regs, psg_gen, psg_mix
//
// Each beat is one request (address write, data write, register read,
// timebase tick or sample request) and yields exactly one result beat. A beat
// is held in the input register, processed against the current generator and
// register state combinationally, and lands in the result register; it waits
// in the input register while the output stalls. One beat can be taken every
// cycle while results are taken as they appear. While a result waits on the
// output the input register still takes one more beat; after that the input
// stalls until the waiting result is taken.
module programmable_sound_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // bus_data, port_value, mix_in
  input  logic [2:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // read_data, sample_out
);

  logic        in_vld_q, in_vld_d;
  logic [2:0]  req_q;
  logic [7:0]  bus_data_q;
  logic [7:0]  port_value_q;
  logic signed [15:0] mix_in_q;

  logic        out_vld_q, out_vld_d;
  logic [7:0]  rd_q, rd_d;
  logic [15:0] smp_q, smp_d;

  logic        out_free, advance, accept;
  logic        addr_we, data_we, tick, env_restart;
  logic [3:0]  addr;
  logic [7:0]  reg_rd;
  logic signed [15:0] mixed;
  psg_pkg::reg_file_t   regs;
  psg_pkg::gen_status_t status;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign addr_we     = advance && (req_q == psg_pkg::REQ_ADDR);
  assign data_we     = advance && (req_q == psg_pkg::REQ_WRITE);
  assign tick        = advance && (req_q == psg_pkg::REQ_TICK);
  assign env_restart = data_we && (addr == psg_pkg::REG_SHAPE);

  psg_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .addr_we_i    (addr_we),
    .data_we_i    (data_we),
    .bus_data_i   (bus_data_q),
    .port_value_i (port_value_q),
    .addr_o       (addr),
    .rd_data_o    (reg_rd),
    .regs_o       (regs)
  );

  psg_gen u_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .env_restart_i (env_restart),
    .env_attack_i  (bus_data_q[2]),
    .regs_i        (regs),
    .status_o      (status)
  );

  psg_mix u_mix (
    .regs_i   (regs),
    .status_i (status),
    .mix_in_i (mix_in_q),
    .sample_o (mixed)
  );

  always_comb begin
    in_vld_d  = accept || (in_vld_q && !out_free);
    out_vld_d = advance || (out_vld_q && !m_axis_tready);
    rd_d      = '0;
    smp_d     = '0;
    unique case (req_q)
      psg_pkg::REQ_READ:   rd_d  = reg_rd;
      psg_pkg::REQ_SAMPLE: smp_d = mixed;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q        <= s_axis_tuser;
      bus_data_q   <= s_axis_tdata[7:0];
      port_value_q <= s_axis_tdata[15:8];
      mix_in_q     <= s_axis_tdata[31:16];
    end
    if (advance) begin
      rd_q  <= rd_d;
      smp_q <= smp_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {smp_q, rd_q};

endmodule

### rtl/core/psg_checker.sv
// port-level checks for the sound generator, bound to the top level
// depends on programmable_sound_generator
module psg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  // a result never carries both a read byte and a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[23:8] == 16'd0))
    else $error("read byte and sample both set");

  // empty output side never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a fresh result has an accepted beat behind it, passed through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without accepted beat");

endmodule

bind programmable_sound_generator psg_checker u_psg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
